// ----- rtl/masked_byte_pattern_scan_macros.svh -----
// Assertion macros shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef MASKED_BYTE_PATTERN_SCAN_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCAN_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPL(label, ante, cons)

`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/mbps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 33;
    localparam int LEN_W       = 5;
    localparam int MASK_W      = 16;
    localparam int PATTERN_W   = 128;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_POSITIONS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_MASK   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       begin_req;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_item_t;

    // Per-cycle control for a window cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Pattern byte aligned to a window position, with its compare enable.
    typedef struct packed {
        logic [7:0] pat;
        logic       en;
    } cell_ref_t;

endpackage

`default_nettype wire

// ----- rtl/mbps_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mbps_cell
(
    input  wire logic               clk,
    input  wire mbps_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]         byte_in,
    input  wire mbps_pkg::cell_ref_t  pat_ref,
    output logic [7:0]              byte_out,
    output logic                    mismatch
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.shift)
        begin
            byte_next = ctrl.clear ? 8'd0 : byte_in;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;
    assign mismatch = pat_ref.en && (byte_reg != pat_ref.pat);

endmodule

`default_nettype wire

// ----- rtl/masked_byte_pattern_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Masked byte pattern scan. Stream memory bytes in ascending address order, with begin_req
// set on the first byte of a scan; the block reports the lowest start address at which
// every masked pattern byte matches, or not-found once the last scan position fails, at
// most one result per scan. The stream shifts through a row of MAX_PATTERN_BYTES-1 window
// cells that all compare in parallel against the pattern aligned to the current length;
// the deciding byte's result is in the output register in the cycle after its transfer.
// Bytes are taken one per cycle except while the input stalls, only while a result waits
// in the output register and the output side stalls. Configuration may be written between
// scans; bytes arriving after a decision and before the next begin are dropped.

`include "masked_byte_pattern_scan_macros.svh"

module masked_byte_pattern_scan
#(
    parameter int MAX_PATTERN_BYTES = 16
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  cfg_we,
    input  wire logic [mbps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire mbps_pkg::in_item_t                    in_data,

    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output mbps_pkg::out_item_t                        out_data
);

    localparam int LEN_W   = mbps_pkg::LEN_W;
    localparam int COUNT_W = mbps_pkg::COUNT_W;
    localparam int ADDR_W  = mbps_pkg::ADDR_W;

    // Configuration registers.
    logic [ADDR_W-1:0]              base_address_reg;
    logic [ADDR_W-1:0]              scan_positions_reg;
    logic [LEN_W-1:0]               pattern_length_reg;
    logic [mbps_pkg::MASK_W-1:0]    compare_mask_reg;
    logic [mbps_pkg::PATTERN_W-1:0] pattern_reg;

    // Scan state. seen_inc_reg holds the byte count as it will be after the next byte.
    logic [COUNT_W-1:0] seen_inc_reg;
    logic [COUNT_W-1:0] seen_inc_next;
    logic               done_reg;
    logic               done_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    mbps_pkg::out_item_t out_data_reg;
    mbps_pkg::out_item_t out_data_next;

    logic               accept;
    logic               begin_scan;
    logic [7:0]         cur_byte;
    logic [LEN_W-1:0]   len_eff;
    logic [COUNT_W-1:0] seen_now;
    logic [COUNT_W:0]   diff;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] positions_ext;
    logic [COUNT_W-1:0] last_pos;
    logic               pos_decides;
    logic               hit;
    logic               emit;
    logic               emit_found;
    logic [ADDR_W-1:0]  emit_address;
    logic               shift;

    mbps_pkg::cell_ref_t aligned [MAX_PATTERN_BYTES];
    logic [7:0]          tap [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] mismatch;

    assign accept     = in_valid && !in_stall;
    assign begin_scan = in_data.begin_req;
    assign cur_byte   = in_data.data_byte;
    assign in_stall   = out_valid_reg && out_stall;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    assign len_eff = (pattern_length_reg > LEN_W'(MAX_PATTERN_BYTES))
                   ? LEN_W'(MAX_PATTERN_BYTES) : pattern_length_reg;

    // Line up each window position with the pattern byte it meets at the current length.
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < MAX_PATTERN_BYTES; b++)
        begin
            idx            = LEN_W'(len_eff - LEN_W'(b) - LEN_W'(1));
            aligned[b].en  = (LEN_W'(b) < len_eff) && compare_mask_reg[idx[3:0]];
            aligned[b].pat = pattern_reg[{idx[3:0], 3'b000} +: 8];
        end
    end

    assign shift    = accept && (begin_scan || !done_reg);
    assign tap[0]   = cur_byte;
    assign mismatch[0] = aligned[0].en && (cur_byte != aligned[0].pat);

    for (genvar k = 0; k < MAX_PATTERN_BYTES - 1; k++)
    begin : g_cell
        mbps_pkg::cell_ctrl_t ctrl;

        assign ctrl.shift = shift;
        assign ctrl.clear = (k != 0) && begin_scan;

        mbps_cell u_cell
        (
            .clk      (clk),
            .ctrl     (ctrl),
            .byte_in  (tap[k]),
            .pat_ref  (aligned[k+1]),
            .byte_out (tap[k+1]),
            .mismatch (mismatch[k+1])
        );
    end

    assign hit = (mismatch == '0);

    // Position arithmetic for the byte now on the input.
    assign seen_now      = begin_scan ? COUNT_W'(1) : seen_inc_reg;
    assign diff          = {1'b0, seen_now} - (COUNT_W+1)'(len_eff);
    assign pos           = diff[COUNT_W-1:0];
    assign positions_ext = COUNT_W'(scan_positions_reg);
    assign last_pos      = positions_ext - COUNT_W'(1);
    assign pos_decides   = !diff[COUNT_W] && (pos < positions_ext);

    always_comb
    begin
        emit         = 1'b0;
        emit_found   = 1'b0;
        emit_address = '0;
        if (begin_scan && (scan_positions_reg == '0))
        begin
            emit = 1'b1;
        end
        else if (begin_scan && (len_eff == '0))
        begin
            emit         = 1'b1;
            emit_found   = 1'b1;
            emit_address = base_address_reg;
        end
        else if ((begin_scan || !done_reg) && pos_decides)
        begin
            if (hit)
            begin
                emit         = 1'b1;
                emit_found   = 1'b1;
                emit_address = base_address_reg + pos[ADDR_W-1:0];
            end
            else if (pos == last_pos)
            begin
                emit = 1'b1;
            end
        end
    end

    always_comb
    begin
        seen_inc_next  = seen_inc_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (shift)
        begin
            seen_inc_next = (seen_now == '1) ? seen_now : seen_now + COUNT_W'(1);
            done_next     = 1'b0;
        end
        if (accept && emit)
        begin
            done_next                   = 1'b1;
            out_valid_next              = 1'b1;
            out_data_next.found         = emit_found;
            out_data_next.match_address = emit_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg   <= '0;
            scan_positions_reg <= '0;
            pattern_length_reg <= '0;
            compare_mask_reg   <= '0;
            pattern_reg        <= '0;
            seen_inc_reg       <= COUNT_W'(1);
            done_reg           <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            seen_inc_reg  <= seen_inc_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mbps_pkg::CFG_BASE_ADDRESS:   base_address_reg   <= cfg_data[ADDR_W-1:0];
                    mbps_pkg::CFG_SCAN_POSITIONS: scan_positions_reg <= cfg_data[ADDR_W-1:0];
                    mbps_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                    mbps_pkg::CFG_COMPARE_MASK:
                        compare_mask_reg <= cfg_data[mbps_pkg::MASK_W-1:0];
                    mbps_pkg::CFG_PATTERN_LOW:    pattern_reg[63:0]   <= cfg_data;
                    mbps_pkg::CFG_PATTERN_HIGH:   pattern_reg[127:64] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `ASSERT_IMPL(a_notfound_addr_zero, out_valid_reg && !out_data_reg.found,
                 out_data_reg.match_address == '0)
    `ASSERT_NEXT(a_emit_sets_done, accept && emit, done_reg && out_valid_reg)
    `ASSERT_IMPL(a_idle_no_result, accept && done_reg && !begin_scan, !emit && !shift)
    `ASSERT_NEXT(a_empty_scan_notfound,
                 accept && begin_scan && (scan_positions_reg == '0),
                 out_valid_reg && !out_data_reg.found)

endmodule

`default_nettype wire

// ----- tb/tb_masked_byte_pattern_scan.sv -----
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scan;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEMS_PER_SETTING = 75;

    typedef struct {
        logic [31:0] base;
        logic [31:0] npos;
        logic [4:0]  len;
        logic [15:0] mask;
        logic [63:0] plo;
        logic [63:0] phi;
    } scan_cfg_t;

    // Tracks the scan state of the block and the match results it still owes.
    class match_checker;
        logic [31:0]  base_addr = '0;
        logic [31:0]  positions = '0;
        logic [4:0]   pat_len = '0;
        logic [15:0]  mask = '0;
        logic [127:0] pattern = '0;
        logic [7:0]   window [15];
        logic [32:0]  seen = '0;
        bit           scan_done = 1'b1;
        mbps_pkg::out_item_t expected_matches [$];
        int           mismatches = 0;

        function new();
            window = '{default: 8'h00};
        endfunction

        function void write_reg(logic [mbps_pkg::CFG_INDEX_W-1:0] idx,
                                logic [mbps_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                mbps_pkg::CFG_BASE_ADDRESS:   base_addr = val[31:0];
                mbps_pkg::CFG_SCAN_POSITIONS: positions = val[31:0];
                mbps_pkg::CFG_PATTERN_LENGTH: pat_len = val[4:0];
                mbps_pkg::CFG_COMPARE_MASK:   mask = val[15:0];
                mbps_pkg::CFG_PATTERN_LOW:    pattern[63:0] = val;
                mbps_pkg::CFG_PATTERN_HIGH:   pattern[127:64] = val;
                default: ;
            endcase
        endfunction

        function void finish_scan(bit hit, logic [31:0] addr);
            mbps_pkg::out_item_t e;
            e.found = hit;
            e.match_address = hit ? addr : '0;
            expected_matches.push_back(e);
            scan_done = 1'b1;
        endfunction

        // Returns 1 when the byte takes part in a scan, 0 when the block drops it.
        function bit take_byte(mbps_pkg::in_item_t it);
            int n;
            logic [32:0] pos;
            bit hit;
            logic [7:0] b;
            n = (pat_len > 16) ? 16 : int'(pat_len);
            if (it.begin_req) begin
                window = '{default: 8'h00};
                seen = '0;
                scan_done = 1'b0;
                if (positions == 0) begin
                    finish_scan(1'b0, '0);
                    return 1'b1;
                end
                if (n == 0) begin
                    finish_scan(1'b1, base_addr);
                    return 1'b1;
                end
            end
            if (scan_done)
                return 1'b0;
            if (seen != '1)
                seen = seen + 1;
            if (seen >= n) begin
                pos = seen - n;
                if (pos < {1'b0, positions}) begin
                    hit = 1'b1;
                    for (int i = 0; i < n; i++) begin
                        if (mask[i]) begin
                            // The newest byte lines up with the last pattern byte.
                            b = (i == n - 1) ? it.data_byte : window[n - 2 - i];
                            if (b != pattern[8*i +: 8])
                                hit = 1'b0;
                        end
                    end
                    if (hit)
                        finish_scan(1'b1, base_addr + pos[31:0]);
                    else if (pos + 1 == {1'b0, positions})
                        finish_scan(1'b0, '0);
                end
            end
            for (int k = 14; k > 0; k--)
                window[k] = window[k - 1];
            window[0] = it.data_byte;
            return 1'b1;
        endfunction

        function void check_result(mbps_pkg::out_item_t got);
            mbps_pkg::out_item_t want;
            if (expected_matches.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, found=%0b match_address=%h",
                         $time, got.found, got.match_address);
                return;
            end
            want = expected_matches.pop_front();
            if (got.found !== want.found) begin
                mismatches++;
                $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
            end
            if (got.match_address !== want.match_address) begin
                mismatches++;
                $display("%0t: match_address expected %h actual %h",
                         $time, want.match_address, got.match_address);
            end
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    mbps_pkg::in_item_t               in_data = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    mbps_pkg::out_item_t              out_data;

    match_checker sb = new();
    scan_cfg_t    cur_cfg;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           items_used = 0;
    int           cycles = 0;

    masked_byte_pattern_scan u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] pat_byte_of(scan_cfg_t c, int i);
        return (i < 8) ? c.plo[8*i +: 8] : c.phi[8*(i - 8) +: 8];
    endfunction

    function automatic int eff_len(scan_cfg_t c);
        return (c.len > 16) ? 16 : int'(c.len);
    endfunction

    // Half the bytes come from the pattern or the extremes, so near misses are common.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return pat_byte_of(cur_cfg, $urandom_range(0, 15));
        if (r < 50)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    function automatic scan_cfg_t random_cfg(int shape);
        scan_cfg_t c;
        int r;
        r = $urandom_range(99);
        if (r < 20)
            c.base = '0;
        else if (r < 45)
            c.base = 32'hFFFF_FFFF - $urandom_range(0, 40);
        else
            c.base = $urandom;
        r = $urandom_range(99);
        if (r < 8)
            c.npos = '0;
        else if (r < 20)
            c.npos = 32'hFFFF_FFFF;
        else if (r < 30)
            c.npos = 32'd1;
        else
            c.npos = $urandom_range(2, 60);
        r = $urandom_range(99);
        if (r < 8)
            c.len = '0;
        else if (r < 18)
            c.len = 5'd16;
        else if (r < 28)
            c.len = 5'($urandom_range(17, 31));
        else if (r < 65)
            c.len = 5'($urandom_range(1, 4));
        else
            c.len = 5'($urandom_range(5, 15));
        r = $urandom_range(99);
        if (r < 15)
            c.mask = 16'hFFFF;
        else if (r < 25)
            c.mask = '0;
        else
            c.mask = 16'($urandom);
        if ($urandom_range(99) < 10) begin
            c.plo = '1;
            c.phi = '1;
        end
        else begin
            c.plo = {$urandom, $urandom};
            c.phi = {$urandom, $urandom};
        end
        if (shape == 1) begin
            c.len = 5'd16;
            c.mask = 16'hFFFF;
            c.npos = 32'hFFFF_FFFF;
            c.base = 32'hFFFF_FFFF - $urandom_range(0, 8);
        end
        else if (shape == 2) begin
            c.len = 5'($urandom_range(17, 31));
            c.npos = $urandom_range(1, 40);
        end
        return c;
    endfunction

    task automatic put_reg(logic [mbps_pkg::CFG_INDEX_W-1:0] idx,
                           logic [mbps_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_config(scan_cfg_t c);
        cur_cfg = c;
        put_reg(mbps_pkg::CFG_BASE_ADDRESS, 64'(c.base));
        put_reg(mbps_pkg::CFG_SCAN_POSITIONS, 64'(c.npos));
        put_reg(mbps_pkg::CFG_PATTERN_LENGTH, 64'(c.len));
        put_reg(mbps_pkg::CFG_COMPARE_MASK, 64'(c.mask));
        put_reg(mbps_pkg::CFG_PATTERN_LOW, c.plo);
        put_reg(mbps_pkg::CFG_PATTERN_HIGH, c.phi);
        cfg_we <= 1'b0;
    endtask

    task automatic send_byte(logic [7:0] b, logic beg);
        mbps_pkg::in_item_t it;
        it.data_byte = b;
        it.begin_req = beg;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (sb.take_byte(it))
            items_used++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // A byte without a result may still be in flight, so keep the clock running after draining.
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Feeding the whole pattern always decides the open scan one way or the other.
    task automatic drain_scan();
        int n;
        n = eff_len(cur_cfg);
        while (!sb.scan_done && n > 0) begin
            for (int i = 0; i < n && !sb.scan_done; i++)
                send_byte(pat_byte_of(cur_cfg, i), 1'b0);
        end
    endtask

    task automatic run_scan();
        int n;
        int body;
        int ins_at;
        int j;
        logic [7:0] b;
        n = eff_len(cur_cfg);
        // Some scans are cut short so the next begin abandons them.
        body = ($urandom_range(99) < 15) ? $urandom_range(0, 8) : 80;
        ins_at = ($urandom_range(99) < 50) ? $urandom_range(0, 24) : -1;
        send_byte(pick_byte(), 1'b1);
        j = 0;
        while (j < body && !sb.scan_done) begin
            if (ins_at >= 0 && j >= ins_at && j < ins_at + n && cur_cfg.mask[j - ins_at])
                b = pat_byte_of(cur_cfg, j - ins_at);
            else
                b = pick_byte();
            send_byte(b, 1'b0);
            j++;
        end
        if (sb.scan_done && $urandom_range(99) < 30)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    endtask

    initial
    begin
        scan_cfg_t c;
        int start;

        cur_cfg = '{base: '0, npos: '0, len: '0, mask: '0, plo: '0, phi: '0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: stray bytes are dropped, a begin with no positions reports not-found.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        settle();

        // Zero length matches at the base right on the begin transfer.
        apply_config('{base: 32'hFFFF_FFFE, npos: 32'hFFFF_FFFF, len: 5'd0,
                       mask: 16'hFFFF, plo: '1, phi: '1});
        send_byte(8'h3C, 1'b1);
        settle();

        // Match at the second position wraps the address to zero; mask bits past the
        // length are ignored and the trailing byte is dropped.
        apply_config('{base: 32'hFFFF_FFFF, npos: 32'd3, len: 5'd2,
                       mask: 16'hFFFF, plo: 64'h0000_0000_0000_FF00, phi: '0});
        send_byte(8'h55, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        settle();

        // Wildcard in the middle, a begin that abandons a scan, then a scan that misses.
        apply_config('{base: 32'h0000_1000, npos: 32'd2, len: 5'd3,
                       mask: 16'h0005, plo: 64'h0000_0000_0055_78AA, phi: '0});
        send_byte(8'h11, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b0);
        settle();

        // All wildcards with length one match at the first byte.
        apply_config('{base: 32'h7FFF_FFFF, npos: 32'd1, len: 5'd1,
                       mask: 16'h0000, plo: '0, phi: '0});
        send_byte(8'h80, 1'b1);
        settle();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 66 : 0;
            recv_stall_pct = (mode == 0) ? 66 : (mode == 1) ? 8 : 0;
            for (int k = 0; k < 8; k++) begin
                c = random_cfg(k);
                apply_config(c);
                start = items_used;
                while (items_used - start < ITEMS_PER_SETTING) begin
                    run_scan();
                    if ($urandom_range(99) < 4)
                        wait_drained();
                end
                drain_scan();
                settle();
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
